// ===== hdl/brf_pkg.sv =====
// Shared types and codes for the circular byte FIFO with peek.
package brf_pkg;

  localparam int FILL_W = 9;

  localparam logic [2:0] MODE_PUSH    = 3'd0;
  localparam logic [2:0] MODE_POP     = 3'd1;
  localparam logic [2:0] MODE_PEEK    = 3'd2;
  localparam logic [2:0] MODE_DISCARD = 3'd3;
  localparam logic [2:0] MODE_CLEAR   = 3'd4;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;
  localparam logic [1:0] STATUS_LONG  = 2'd3;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] data_in;
    logic [8:0] run_length;
    logic [7:0] offset;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [7:0]        data_out;
    logic              data_valid;
    logic              last;
    logic [FILL_W-1:0] fill_level;
    logic              is_empty;
    logic              is_full;
  } out_t;

endpackage

// ===== hdl/byte_ring_fifo_with_peek.sv =====
// Top level of the circular byte FIFO with peek: sequencer, byte RAM and result queue.
//
// Input channel in_valid/in_ready/in_data carries one command item: push,
// pop, peek, discard or clear. Result channel out_valid/out_ready/out_data
// returns the result items; every result carries status, fill level and the
// empty/full flags, and the final result of a command has last set.
// Push, discard, clear and every rejected command give one result; the
// sequencer stays idle, so the next command can be accepted in the
// following cycle unless a full queue holds issue. A pop or peek of N
// bytes is checked first, then the run state issues one byte per cycle
// while issue is not held, limited by the single read port of the byte
// RAM. Every result passes the read stage and the queue before out_valid.
// Results pass through a read stage and a two-entry queue; a stalled
// receiver holds issue once two results wait in the read stage and the queue
// together; nothing is dropped. Reset clears the pointers, fill count and
// queue; the byte RAM keeps its contents and needs no clearing pass.
module byte_ring_fifo_with_peek
  import brf_pkg::*;
#(
  parameter int DEPTH   = 256,
  parameter int MAX_RUN = 64
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int PW  = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int RLW = $clog2(MAX_RUN + 1);
  localparam int SW  = ((PW > CW) ? PW : CW) > 9 ? ((PW > CW) ? PW : CW) + 1 : 10;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] p,
                                             input logic [SW-1:0] n);
    logic [SW-1:0] s;
    s = SW'(p) + n;
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return PW'(s);
  endfunction

  logic           state_r, state_nxt;
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [PW-1:0]  run_ptr_r, run_ptr_nxt;
  logic [RLW-1:0] run_left_r, run_left_nxt;
  logic           run_pop_r, run_pop_nxt;
  logic           s1_v_r, s1_v_nxt;
  out_t           s1_r, s1_nxt;
  out_t           q_r [2];
  logic           q_head_r;
  logic [1:0]     q_cnt_r;

  logic           ram_we;
  logic [7:0]     ram_rdata;
  logic [1:0]     occ;
  logic           pop_out;
  logic           can_issue;
  logic           accept;
  logic           issue;
  logic [1:0]     iss_status;
  logic           iss_data;
  logic           iss_last;
  logic [SW-1:0]  len_x, off_x, cnt_x;
  logic           full_now;
  logic           q_tail;
  out_t           q_in;

  brf_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr_r),
    .wdata (in_data.data_in),
    .raddr (run_ptr_r),
    .rdata (ram_rdata)
  );

  // queue plus read stage never hold more than two results
  assign occ       = q_cnt_r + {1'b0, s1_v_r};
  assign pop_out   = out_valid && out_ready;
  assign can_issue = (occ < 2'd2) || ((occ == 2'd2) && pop_out);
  assign in_ready  = (state_r == ST_IDLE) && can_issue;
  assign accept    = in_valid && in_ready;

  assign len_x    = SW'(in_data.run_length);
  assign off_x    = SW'(in_data.offset);
  assign cnt_x    = SW'(cnt_r);
  assign full_now = (cnt_r == CW'(DEPTH));

  always_comb begin
    state_nxt    = state_r;
    wr_ptr_nxt   = wr_ptr_r;
    rd_ptr_nxt   = rd_ptr_r;
    cnt_nxt      = cnt_r;
    run_ptr_nxt  = run_ptr_r;
    run_left_nxt = run_left_r;
    run_pop_nxt  = run_pop_r;
    ram_we       = 1'b0;
    issue        = 1'b0;
    iss_status   = STATUS_OK;
    iss_data     = 1'b0;
    iss_last     = 1'b1;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          issue = 1'b1;
          unique case (in_data.mode)
            MODE_PUSH: begin
              if (full_now) begin
                iss_status = STATUS_FULL;
              end else begin
                ram_we     = 1'b1;
                wr_ptr_nxt = wrap_add(wr_ptr_r, SW'(1));
                cnt_nxt    = cnt_r + CW'(1);
              end
            end
            MODE_POP, MODE_PEEK: begin
              if (in_data.run_length > 9'(MAX_RUN)) begin
                iss_status = STATUS_LONG;
              end else if ((in_data.mode == MODE_POP) && (len_x > cnt_x)) begin
                iss_status = STATUS_EMPTY;
              end else if ((in_data.mode == MODE_PEEK) &&
                           ((off_x > cnt_x) || (len_x > cnt_x - off_x))) begin
                iss_status = STATUS_EMPTY;
              end else if (in_data.run_length != 9'd0) begin
                // run bytes are issued from the run state
                issue        = 1'b0;
                state_nxt    = ST_RUN;
                run_left_nxt = RLW'(in_data.run_length);
                run_pop_nxt  = (in_data.mode == MODE_POP);
                run_ptr_nxt  = (in_data.mode == MODE_POP) ? rd_ptr_r :
                               wrap_add(rd_ptr_r, off_x);
              end
            end
            MODE_DISCARD: begin
              if (len_x > cnt_x) begin
                iss_status = STATUS_EMPTY;
              end else begin
                rd_ptr_nxt = wrap_add(rd_ptr_r, len_x);
                cnt_nxt    = cnt_r - CW'(in_data.run_length);
              end
            end
            MODE_CLEAR: begin
              wr_ptr_nxt = '0;
              rd_ptr_nxt = '0;
              cnt_nxt    = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_RUN: begin
        if (can_issue) begin
          issue        = 1'b1;
          iss_data     = 1'b1;
          iss_last     = (run_left_r == RLW'(1));
          run_ptr_nxt  = wrap_add(run_ptr_r, SW'(1));
          run_left_nxt = run_left_r - RLW'(1);
          if (run_pop_r) begin
            rd_ptr_nxt = wrap_add(run_ptr_r, SW'(1));
            cnt_nxt    = cnt_r - CW'(1);
          end
          if (iss_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    s1_v_nxt          = issue;
    s1_nxt            = s1_r;
    if (issue) begin
      s1_nxt.status     = iss_status;
      s1_nxt.data_out   = '0;
      s1_nxt.data_valid = iss_data;
      s1_nxt.last       = iss_last;
      s1_nxt.fill_level = FILL_W'(cnt_nxt);
      s1_nxt.is_empty   = (cnt_nxt == '0);
      s1_nxt.is_full    = (cnt_nxt == CW'(DEPTH));
    end
  end

  // read data is registered in the RAM alongside the read stage; merge it here
  always_comb begin
    q_in          = s1_r;
    q_in.data_out = s1_r.data_valid ? ram_rdata : 8'd0;
  end

  assign q_tail    = q_head_r ^ q_cnt_r[0];
  assign out_valid = (q_cnt_r != 2'd0);
  assign out_data  = q_r[q_head_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      s1_v_r   <= 1'b0;
      q_head_r <= 1'b0;
      q_cnt_r  <= 2'd0;
    end else begin
      state_r  <= state_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
      s1_v_r   <= s1_v_nxt;
      q_head_r <= q_head_r ^ pop_out;
      q_cnt_r  <= q_cnt_r + {1'b0, s1_v_r} - {1'b0, pop_out};
    end
  end

  always_ff @(posedge clk) begin
    run_ptr_r  <= run_ptr_nxt;
    run_left_r <= run_left_nxt;
    run_pop_r  <= run_pop_nxt;
    s1_r       <= s1_nxt;
    if (s1_v_r) begin
      q_r[q_tail] <= q_in;
    end
  end

endmodule

// ===== hdl/brf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module brf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
